// ===== design/rc4_salted_stream_cipher_core_defines.svh =====
// Assertion macros for the salted RC4 core.
// Used by the top level only; no other dependencies.
`ifndef RC4_SALTED_STREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_SALTED_STREAM_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RC4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rc4 core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RC4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rc4 core: next-cycle check failed");

`endif

// ===== design/rc4_pkg.sv =====
// Shared types and constants for the salted RC4 core.
// Used by rc4_ctrl, rc4_dp and the top level; no dependencies.
package rc4_pkg;

    localparam int KEY_BYTES  = 256;
    localparam int SALT_BYTES = 16;
    localparam int KEY_AW     = $clog2(KEY_BYTES);
    localparam int SALT_AW    = (SALT_BYTES > 1) ? $clog2(SALT_BYTES) : 1;
    localparam int CFG_W      = 9;
    localparam int PERM_AW    = 8;

    // Request modes.
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_SALT = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_wr;
        logic salt_wr;
        logic capture;
        logic init_start;
        logic init_wr;
        logic ksa_rd_n;
        logic ksa_rd_j;
        logic ksa_wr_n;
        logic ksa_wr_j;
        logic idx_clear;
        logic prga_rd_i;
        logic prga_rd_j;
        logic prga_wr_i;
        logic prga_wr_j;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_last;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== design/rc4_salted_stream_cipher_core.sv =====
// Top level of the salted RC4 stream cipher core.
// Depends on rc4_pkg, rc4_ctrl, rc4_dp and the assertion macro header.
//
//   channel   direction  handshake                  payload
//   in        request    i_in_valid / o_in_ready    i_mode, i_position, i_value_byte,
//                                                   i_new_message
//   out       result     o_out_valid / i_out_ready  o_out_byte
//   cfg       write      i_cfg_we                   i_cfg_data (key length)
//
// A key or salt write request is done in its accept cycle. A data request
// is accepted and then takes four steps on the permutation memory, which
// has one read port and one write port (read S[i], read S[j], write S[i] with
// the output read, write S[j]).
// A data request that starts a message first loads the identity permutation
// into all 256 entries and then runs the key schedule (four memory steps
// per entry). Reset is synchronous and active low; it clears the indices, the
// key length register and the control state. When a result is still waiting
// downstream, the core keeps taking requests and stalls only at the final step
// of the next data request.
`include "rc4_salted_stream_cipher_core_defines.svh"

module rc4_salted_stream_cipher_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rc4_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_mode,
    input  logic [7:0]                i_position,
    input  logic [7:0]                i_value_byte,
    input  logic                      i_new_message,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [7:0]                o_out_byte
);
    import rc4_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic [4:0] w_perm_writes;

    // The controller owns all sequencing; the datapath only acts on commands.
    rc4_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_new_message (i_new_message),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    rc4_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_position   (i_position),
        .i_value_byte (i_value_byte),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte)
    );

    // Every command that writes the permutation memory, one bit each.
    assign w_perm_writes = {w_cmd.init_wr, w_cmd.ksa_wr_n, w_cmd.ksa_wr_j,
                            w_cmd.prga_wr_i, w_cmd.prga_wr_j};

    // The permutation memory has one write port: at most one write per cycle.
    `RC4_ASSERT_NOW(a_one_perm_write, 1'b1, $onehot0(w_perm_writes))
    // A new result appears only after the final keystream step.
    `RC4_ASSERT_NOW(a_out_from_step, $rose(o_out_valid), $past(w_cmd.prga_wr_j))
    // An accepted data request makes the core busy on the next cycle.
    `RC4_ASSERT_NEXT(a_data_busy, i_in_valid && o_in_ready && (i_mode == MODE_DATA), !o_in_ready)
    // Store writes never block the input channel.
    `RC4_ASSERT_NEXT(a_key_no_stall, i_in_valid && o_in_ready && (i_mode == MODE_KEY || i_mode == MODE_SALT), o_in_ready)

endmodule

// ===== design/rc4_dp.sv =====
// Datapath of the salted RC4 core: permutation and key memories, salt store,
// indices and output register. Depends on rc4_pkg.
module rc4_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rc4_pkg::t_dp_cmd          i_cmd,
    output rc4_pkg::t_dp_stat         o_stat,
    input  logic                      i_cfg_we,
    input  logic [rc4_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [7:0]                i_position,
    input  logic [7:0]                i_value_byte,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [7:0]                o_out_byte
);
    import rc4_pkg::*;

    logic [7:0]         r_perm [0:(1 << PERM_AW)-1];
    logic [7:0]         r_key_mem [0:KEY_BYTES-1];
    logic [7:0]         r_salt [0:SALT_BYTES-1];

    logic [CFG_W-1:0]   r_key_length;
    logic [7:0]         r_i, n_i;
    logic [7:0]         r_j, n_j;
    logic [7:0]         r_n;
    logic [CFG_W-1:0]   r_kp;
    logic [7:0]         r_sn;
    logic [7:0]         r_sj;
    logic [7:0]         r_val;
    logic [7:0]         r_perm_q;
    logic [7:0]         r_key_q;
    logic [7:0]         r_salt_q;
    logic               r_key_sel;
    logic               r_hit_i;
    logic               r_hit_j;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;

    logic [CFG_W-1:0]   w_klen;
    logic [CFG_W-1:0]   w_kp_last;
    logic [CFG_W-1:0]   w_salt_off;
    logic               w_perm_we;
    logic [7:0]         w_perm_wa;
    logic [7:0]         w_perm_wd;
    logic               w_perm_re;
    logic [7:0]         w_perm_ra;
    logic [7:0]         w_kbyte;
    logic [7:0]         w_tsum;
    logic [7:0]         w_ks;

    // Key length in use is clamped to the key store depth.
    assign w_klen     = (r_key_length > CFG_W'(KEY_BYTES)) ? CFG_W'(KEY_BYTES) : r_key_length;
    assign w_kp_last  = w_klen + CFG_W'(SALT_BYTES - 1);
    assign w_salt_off = r_kp - w_klen;
    assign w_kbyte    = r_key_sel ? r_key_q : r_salt_q;
    assign w_tsum     = 8'(r_sn + r_perm_q);
    assign w_ks       = r_hit_j ? r_sn : (r_hit_i ? r_sj : r_perm_q);

    always_comb begin
        n_i = 8'(r_i + 8'd1);
        n_j = r_j;
        if (i_cmd.ksa_rd_j) begin
            n_j = 8'(r_j + r_perm_q + w_kbyte);
        end else if (i_cmd.prga_rd_j) begin
            n_j = 8'(r_j + r_perm_q);
        end
    end

    // Permutation memory port selection.
    always_comb begin
        w_perm_we = 1'b0;
        w_perm_wa = r_n;
        w_perm_wd = r_n;
        w_perm_re = 1'b0;
        w_perm_ra = r_n;
        if (i_cmd.init_wr) begin
            w_perm_we = 1'b1;
        end
        if (i_cmd.ksa_rd_n) begin
            w_perm_re = 1'b1;
        end
        if (i_cmd.ksa_rd_j || i_cmd.prga_rd_j) begin
            w_perm_re = 1'b1;
            w_perm_ra = n_j;
        end
        if (i_cmd.ksa_wr_n) begin
            w_perm_we = 1'b1;
            w_perm_wd = r_perm_q;
        end
        if (i_cmd.ksa_wr_j || i_cmd.prga_wr_j) begin
            w_perm_we = 1'b1;
            w_perm_wa = r_j;
            w_perm_wd = r_sn;
        end
        if (i_cmd.prga_rd_i) begin
            w_perm_re = 1'b1;
            w_perm_ra = n_i;
        end
        if (i_cmd.prga_wr_i) begin
            w_perm_we = 1'b1;
            w_perm_wa = r_i;
            w_perm_wd = r_perm_q;
            w_perm_re = 1'b1;
            w_perm_ra = w_tsum;
        end
    end

    // A read at the same edge as a write returns the old contents.
    always_ff @(posedge i_clk) begin
        if (w_perm_we) begin
            r_perm[w_perm_wa] <= w_perm_wd;
        end
        if (w_perm_re) begin
            r_perm_q <= r_perm[w_perm_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr && ({1'b0, i_position} < CFG_W'(KEY_BYTES))) begin
            r_key_mem[i_position[KEY_AW-1:0]] <= i_value_byte;
        end
        if (i_cmd.ksa_rd_n) begin
            r_key_q <= r_key_mem[r_kp[KEY_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.salt_wr && (i_position < 8'(SALT_BYTES))) begin
            r_salt[i_position[SALT_AW-1:0]] <= i_value_byte;
        end
        if (i_cmd.ksa_rd_n) begin
            r_salt_q  <= r_salt[w_salt_off[SALT_AW-1:0]];
            r_key_sel <= r_kp < w_klen;
        end
        if (i_cmd.capture) begin
            r_val <= i_value_byte;
        end
        if (i_cmd.ksa_rd_j || i_cmd.prga_rd_j) begin
            r_sn <= r_perm_q;
        end
        if (i_cmd.prga_wr_i) begin
            r_sj    <= r_perm_q;
            r_hit_i <= w_tsum == r_i;
            r_hit_j <= w_tsum == r_j;
        end
        if (i_cmd.prga_wr_j) begin
            r_out_byte <= r_val ^ w_ks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_n          <= '0;
            r_kp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key_length <= i_cfg_data;
            end
            if (i_cmd.init_start) begin
                r_n  <= '0;
                r_j  <= '0;
                r_kp <= '0;
            end
            if (i_cmd.init_wr) begin
                r_n <= 8'(r_n + 8'd1);
            end
            if (i_cmd.ksa_rd_j || i_cmd.prga_rd_j) begin
                r_j <= n_j;
            end
            if (i_cmd.ksa_wr_j) begin
                r_n  <= 8'(r_n + 8'd1);
                r_kp <= (r_kp == w_kp_last) ? '0 : CFG_W'(r_kp + 1'b1);
            end
            if (i_cmd.idx_clear) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_cmd.prga_rd_i) begin
                r_i <= n_i;
            end
            if (i_cmd.prga_wr_j) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.n_last   = r_n == 8'hFF;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;

endmodule

// ===== design/rc4_ctrl.sv =====
// Controller of the salted RC4 core: sequences store writes, the schedule
// and keystream steps. Depends on rc4_pkg.
module rc4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic              i_new_message,
    input  rc4_pkg::t_dp_stat i_stat,
    output rc4_pkg::t_dp_cmd  o_cmd
);
    import rc4_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_K_RD_N  = 4'd2;
    localparam logic [3:0] S_K_RD_J  = 4'd3;
    localparam logic [3:0] S_K_WR_N  = 4'd4;
    localparam logic [3:0] S_K_WR_J  = 4'd5;
    localparam logic [3:0] S_P_RD_I  = 4'd6;
    localparam logic [3:0] S_P_RD_J  = 4'd7;
    localparam logic [3:0] S_P_WR_I  = 4'd8;
    localparam logic [3:0] S_P_WR_J  = 4'd9;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_KEY:  o_cmd.key_wr  = 1'b1;
                        MODE_SALT: o_cmd.salt_wr = 1'b1;
                        MODE_DATA: begin
                            o_cmd.capture = 1'b1;
                            if (i_new_message) begin
                                o_cmd.init_start = 1'b1;
                                n_state          = S_INIT;
                            end else begin
                                n_state = S_P_RD_I;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.n_last) begin
                    n_state = S_K_RD_N;
                end
            end
            S_K_RD_N: begin
                o_cmd.ksa_rd_n = 1'b1;
                n_state        = S_K_RD_J;
            end
            S_K_RD_J: begin
                o_cmd.ksa_rd_j = 1'b1;
                n_state        = S_K_WR_N;
            end
            S_K_WR_N: begin
                o_cmd.ksa_wr_n = 1'b1;
                n_state        = S_K_WR_J;
            end
            S_K_WR_J: begin
                o_cmd.ksa_wr_j = 1'b1;
                if (i_stat.n_last) begin
                    o_cmd.idx_clear = 1'b1;
                    n_state         = S_P_RD_I;
                end else begin
                    n_state = S_K_RD_N;
                end
            end
            S_P_RD_I: begin
                o_cmd.prga_rd_i = 1'b1;
                n_state         = S_P_RD_J;
            end
            S_P_RD_J: begin
                o_cmd.prga_rd_j = 1'b1;
                n_state         = S_P_WR_I;
            end
            S_P_WR_I: begin
                o_cmd.prga_wr_i = 1'b1;
                n_state         = S_P_WR_J;
            end
            S_P_WR_J: begin
                // Hold here until the output register can take the byte.
                if (!i_stat.out_busy) begin
                    o_cmd.prga_wr_j = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

endmodule

// ===== bench/rc4_cipher_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the salted RC4 core: it watches the request, result and key-length ports.
// It keeps its own cipher state and compares every output byte. Depends on rc4_pkg.
module rc4_cipher_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rc4_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_mode,
    input  logic [7:0]                i_position,
    input  logic [7:0]                i_value_byte,
    input  logic                      i_new_message,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [7:0]                i_out_byte,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_results_checked
);

    logic [7:0]                sbox [0:255];
    logic [7:0]                key_mem [0:rc4_pkg::KEY_BYTES-1];
    logic [7:0]                salt_mem [0:rc4_pkg::SALT_BYTES-1];
    logic [7:0]                idx_i;
    logic [7:0]                idx_j;
    logic [rc4_pkg::CFG_W-1:0] key_len_reg;
    logic [7:0]                cipher_bytes_q [$];
    int                        fails = 0;
    int                        checked = 0;

    // Key schedule over key bytes, then salt bytes, cycling with period
    // key length plus salt length.
    task automatic load_schedule();
        int         klen;
        int         period;
        int         pos;
        logic [7:0] j;
        logic [7:0] kb;
        logic [7:0] t;
        klen = (key_len_reg > rc4_pkg::KEY_BYTES) ? rc4_pkg::KEY_BYTES : int'(key_len_reg);
        period = klen + rc4_pkg::SALT_BYTES;
        for (int n = 0; n < 256; n++) begin
            sbox[n] = 8'(n);
        end
        j = 8'd0;
        for (int n = 0; n < 256; n++) begin
            pos = n % period;
            kb = (pos < klen) ? key_mem[pos] : salt_mem[pos - klen];
            j = j + sbox[n] + kb;
            t = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
        end
        idx_i = 8'd0;
        idx_j = 8'd0;
    endtask

    task automatic step_keystream(output logic [7:0] ks);
        logic [7:0] t;
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        t = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        ks = sbox[8'(sbox[idx_i] + sbox[idx_j])];
    endtask

    always @(posedge i_clk) begin
        logic [7:0] ks;
        logic [7:0] want;
        if (!i_rst_n) begin
            cipher_bytes_q.delete();
            idx_i = 8'd0;
            idx_j = 8'd0;
            key_len_reg = '0;
        end else begin
            if (i_cfg_we) begin
                key_len_reg = i_cfg_data;
            end
            // Results are checked before this edge's request is modeled.
            if (i_out_valid && i_out_ready) begin
                if (cipher_bytes_q.size() == 0) begin
                    $display("%0t: unexpected out_byte %02h, expected none", $time, i_out_byte);
                    fails++;
                end else begin
                    want = cipher_bytes_q.pop_front();
                    checked++;
                    if (i_out_byte !== want) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, i_out_byte);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_mode)
                    rc4_pkg::MODE_KEY: begin
                        key_mem[i_position] = i_value_byte;
                    end
                    rc4_pkg::MODE_SALT: begin
                        if (i_position < rc4_pkg::SALT_BYTES) begin
                            salt_mem[i_position] = i_value_byte;
                        end
                    end
                    rc4_pkg::MODE_DATA: begin
                        if (i_new_message) begin
                            load_schedule();
                        end
                        step_keystream(ks);
                        cipher_bytes_q.push_back(i_value_byte ^ ks);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= cipher_bytes_q.size();
        o_fail_count <= fails;
        o_results_checked <= checked;
    end

endmodule

// ===== bench/tb_rc4_salted_stream_cipher_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the salted RC4 core: clock, reset, request and key-length stimulus.
// Depends on rc4_pkg, the core and rc4_cipher_checker, which predicts and compares.
module tb_rc4_salted_stream_cipher_core;

    // The unused request mode; the core must drop it without a result.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 8_000_000;
    localparam int HOLD_CYCLES    = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASES         = 9;
    localparam int PHASE_REQUESTS = 130;
    localparam int KEY_LEN_RANDOM = -1;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [rc4_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_mode = rc4_pkg::MODE_KEY;
    logic [7:0]                i_position = 8'd0;
    logic [7:0]                i_value_byte = 8'd0;
    logic                      i_new_message = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [7:0]                o_out_byte;

    int fail_count;
    int pending;
    int results_checked;

    int cycle_count = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // Stimulus-side bookkeeping: which key and salt entries hold a defined
    // value, and whether a key schedule has run. A schedule is only started
    // once every entry it will read has been written.
    bit key_loaded [rc4_pkg::KEY_BYTES];
    bit salt_loaded [rc4_pkg::SALT_BYTES];
    bit schedule_ready = 1'b0;
    int key_len_now = 0;
    int request_count = 0;
    int settings_used = 0;

    // Plan of the random phases. Key lengths include both ends of the range,
    // a value above 256 that must be clamped, and the lengths around 240 where
    // the salt stops fitting entirely into the 256 schedule steps.
    int key_len_plan [PHASES] = '{256, 511, 240, 241, 1, 16, KEY_LEN_RANDOM, 0, KEY_LEN_RANDOM};
    int sender_plan [PHASES]  = '{0, 62, 0, 21, 0, 62, 0, 21, 0};
    int recv_plan [PHASES]    = '{0, 0, 62, 21, 0, 0, 62, 21, 0};

    rc4_salted_stream_cipher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value_byte  (i_value_byte),
        .i_new_message (i_new_message),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte)
    );

    rc4_cipher_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_position        (i_position),
        .i_value_byte      (i_value_byte),
        .i_new_message     (i_new_message),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_out_byte        (o_out_byte),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog. The limit is several times the slowest legal run: every data
    // request starting a message and paying the full schedule cost.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side. Normally it stalls at random with the current percentage.
    // A hold-off request from the stimulus process makes it refuse results for
    // a long stretch, counted here, so that the core backs up and stops taking
    // requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one request and returns at the edge where it is accepted. Idle
    // cycles before it drop valid; back-to-back requests keep valid high.
    task automatic send_request(input logic [1:0] mode, input logic [7:0] pos,
                                input logic [7:0] val, input logic start);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_position <= pos;
        i_value_byte <= val;
        i_new_message <= start;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        // Only requests that change state or produce a result are counted.
        case (mode)
            rc4_pkg::MODE_KEY: begin
                key_loaded[pos] = 1'b1;
                request_count++;
            end
            rc4_pkg::MODE_SALT: begin
                if (pos < rc4_pkg::SALT_BYTES) begin
                    salt_loaded[pos] = 1'b1;
                    request_count++;
                end
            end
            rc4_pkg::MODE_DATA: begin
                if (start) begin
                    schedule_ready = 1'b1;
                end
                request_count++;
            end
            default: begin
            end
        endcase
    endtask

    // Stops offering requests until every predicted byte has come out, then
    // lets the core finish any trailing write.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The key length register is only written with the core idle.
    task automatic set_key_length(input int value);
        wait_for_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value[rc4_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_len_now = (value > rc4_pkg::KEY_BYTES) ? rc4_pkg::KEY_BYTES : value;
        settings_used++;
    endtask

    // A key write, a salt write (sometimes out of range) or an unused-mode
    // request, all with random content and a random new_message bit.
    task automatic random_write();
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            send_request(MODE_UNUSED, 8'($urandom()), 8'($urandom()), 1'($urandom()));
        end else if (kind <= 5) begin
            send_request(rc4_pkg::MODE_KEY, 8'($urandom()), 8'($urandom()), 1'($urandom()));
        end else if ($urandom_range(9) == 0) begin
            send_request(rc4_pkg::MODE_SALT, 8'($urandom_range(255, rc4_pkg::SALT_BYTES)),
                         8'($urandom()), 1'($urandom()));
        end else begin
            send_request(rc4_pkg::MODE_SALT, 8'($urandom_range(rc4_pkg::SALT_BYTES - 1)),
                         8'($urandom()), 1'($urandom()));
        end
    endtask

    // Writes every key and salt entry that the next schedule reads and that
    // has never been written. With a key length of 256 the salt is not read
    // at all; above 240 only part of it is.
    task automatic fill_key_material();
        int salt_used;
        salt_used = (key_len_now >= rc4_pkg::KEY_BYTES) ? 0 :
                    (256 - key_len_now < rc4_pkg::SALT_BYTES) ? 256 - key_len_now :
                    rc4_pkg::SALT_BYTES;
        for (int k = 0; k < key_len_now; k++) begin
            if (!key_loaded[k]) begin
                send_request(rc4_pkg::MODE_KEY, 8'(k), 8'($urandom()), 1'($urandom()));
            end
        end
        for (int s = 0; s < salt_used; s++) begin
            if (!salt_loaded[s]) begin
                send_request(rc4_pkg::MODE_SALT, 8'(s), 8'($urandom()), 1'($urandom()));
            end
        end
    endtask

    // One message: a few writes that change the key material, then a run of
    // data bytes. Most messages start with a fresh key schedule; some just
    // continue the keystream of the previous one. Writes and unused-mode
    // requests are occasionally mixed in between data bytes.
    task automatic random_message();
        int  n_data;
        bit  fresh;
        repeat ($urandom_range(3)) random_write();
        fresh = !schedule_ready || ($urandom_range(9) != 0);
        if (fresh) begin
            fill_key_material();
        end
        n_data = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int d = 0; d < n_data; d++) begin
            if ($urandom_range(9) == 0) begin
                random_write();
            end
            send_request(rc4_pkg::MODE_DATA, 8'($urandom()), 8'($urandom()), fresh && d == 0);
        end
    endtask

    initial begin
        int  phase_start;
        int  len;
        bit  hold_done;
        hold_done = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with a zero key length, so the schedule runs on the
        // salt alone. Salt bytes span 00 to ff.
        set_key_length(0);
        for (int s = 0; s < rc4_pkg::SALT_BYTES; s++) begin
            send_request(rc4_pkg::MODE_SALT, 8'(s), 8'(s * 17), 1'b0);
        end
        // Key writes at both ends of the store; new_message on a write is ignored.
        send_request(rc4_pkg::MODE_KEY, 8'd255, 8'hff, 1'b1);
        send_request(rc4_pkg::MODE_KEY, 8'd0, 8'h00, 1'b0);
        // Salt writes past the end of the salt store are dropped.
        send_request(rc4_pkg::MODE_SALT, 8'd16, 8'h55, 1'b0);
        send_request(rc4_pkg::MODE_SALT, 8'd255, 8'haa, 1'b1);
        // The unused mode gives no result, even with every field at its top.
        send_request(MODE_UNUSED, 8'hff, 8'hff, 1'b1);
        // Data bytes: one starting a message, one continuing it, one restarting.
        send_request(rc4_pkg::MODE_DATA, 8'h00, 8'h00, 1'b1);
        send_request(rc4_pkg::MODE_DATA, 8'hff, 8'hff, 1'b0);
        send_request(rc4_pkg::MODE_DATA, 8'h80, 8'h5a, 1'b1);

        // Random phases, each under its own key length and idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            len = (key_len_plan[p] == KEY_LEN_RANDOM) ? $urandom_range(300) : key_len_plan[p];
            set_key_length(len);
            sender_idle_pct = sender_plan[p];
            recv_stall_pct <= recv_plan[p];
            phase_start = request_count;
            while (request_count - phase_start < PHASE_REQUESTS) begin
                // In the first phase the result side holds off for a long
                // stretch while requests keep coming with no gaps.
                if (p == 0 && !hold_done && request_count - phase_start >= 40) begin
                    hold_requests <= hold_requests + 1;
                    hold_done = 1'b1;
                end
                // Midway through one phase the sender pauses until the core
                // has delivered every outstanding byte.
                if (p == 4 && request_count - phase_start >= PHASE_REQUESTS / 2 &&
                    request_count - phase_start < PHASE_REQUESTS / 2 + 15) begin
                    wait_for_results();
                end
                random_message();
            end
        end

        wait_for_results();
        $display("Run covered %0d requests under %0d key-length settings from 0 to 511.",
                 request_count, settings_used);
        $display("Checked %0d cipher bytes with sender gaps, result stalls and a %0d-cycle hold-off.",
                 results_checked, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
